/* rtl/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and constants for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Parser phase, one-hot coded.
    typedef enum logic [7:0] {
        PH_DELTA    = 8'b0000_0001,
        PH_STATUS   = 8'b0000_0010,
        PH_DATA1    = 8'b0000_0100,
        PH_DATA2    = 8'b0000_1000,
        PH_SYSLEN   = 8'b0001_0000,
        PH_METATYPE = 8'b0010_0000,
        PH_METALEN  = 8'b0100_0000,
        PH_PAYLOAD  = 8'b1000_0000
    } mtep_phase_t;

    // Result kinds.
    localparam logic [3:0] KIND_NOTE_OFF      = 4'd0;
    localparam logic [3:0] KIND_NOTE_ON       = 4'd1;
    localparam logic [3:0] KIND_KEY_PRESSURE  = 4'd2;
    localparam logic [3:0] KIND_CONTROLLER    = 4'd3;
    localparam logic [3:0] KIND_PROGRAM       = 4'd4;
    localparam logic [3:0] KIND_CHAN_PRESSURE = 4'd5;
    localparam logic [3:0] KIND_BEND          = 4'd6;
    localparam logic [3:0] KIND_SYSEX         = 4'd7;
    localparam logic [3:0] KIND_META          = 4'd8;
    localparam logic [3:0] KIND_PAYLOAD       = 4'd9;

    // Status bytes and status high nibbles.
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
    localparam logic [3:0] HI_NOTE_OFF       = 4'h8;
    localparam logic [3:0] HI_NOTE_ON        = 4'h9;
    localparam logic [3:0] HI_KEY_PRESSURE   = 4'hA;
    localparam logic [3:0] HI_PROGRAM        = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESSURE  = 4'hD;
    localparam logic [3:0] HI_BEND           = 4'hE;
    localparam logic [3:0] HI_SYSTEM         = 4'hF;

    // Stream widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 5;

    // One input item as held in the input register.
    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
        logic        new_chunk;
        logic [15:0] track_index;
    } mtep_item_t;

    // One result item as produced by the parser step.
    typedef struct packed {
        logic        valid;
        logic [3:0]  kind;
        logic [3:0]  channel;
        logic [13:0] data1;
        logic [7:0]  data2;
        logic [31:0] delta;
        logic [31:0] tick;
        logic [31:0] length;
        logic [15:0] track;
        logic        end_of_track;
        logic        last_in_event;
    } mtep_result_t;

endpackage

/* rtl/mtep_in_stage.sv */
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte item and hands it to the parser when the result
// side has room.
// ----------------------------------------------------------------------------
module mtep_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mtep_pkg::IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0], track_index[23:8]
    input  logic                            s_tuser,   // new_chunk
    input  logic                            out_free,
    output logic                            advance,
    output mtep_pkg::mtep_item_t            item
);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic        chunk_reg;
    logic [15:0] track_reg;
    logic        take;

    // The held item moves on whenever the result register can take it.
    assign advance  = valid_reg && out_free;
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg  <= s_tdata[7:0];
            track_reg <= s_tdata[23:8];
            chunk_reg <= s_tuser;
        end
    end

    assign item.valid       = valid_reg;
    assign item.data_byte   = byte_reg;
    assign item.new_chunk   = chunk_reg;
    assign item.track_index = track_reg;

endmodule

/* rtl/mtep_step.sv */
// ----------------------------------------------------------------------------
// Parser step
// Holds the parser state and decodes one track byte per advance, giving at
// most one result item.
// ----------------------------------------------------------------------------
module mtep_step (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  mtep_pkg::mtep_item_t   item,
    output mtep_pkg::mtep_result_t result
);

    mtep_pkg::mtep_phase_t phase_reg, phase_next;
    logic [31:0] vlq_reg, vlq_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] delta_reg, delta_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  meta_reg, meta_next;
    logic [31:0] payload_reg, payload_next;
    logic [15:0] track_reg, track_next;
    logic        ended_reg, ended_next;

    // State as seen after an optional chunk restart.
    mtep_pkg::mtep_phase_t ph;
    logic [31:0] b_vlq, b_tick, b_delta, b_payload;
    logic [7:0]  b_running, b_status, b_first, b_meta;
    logic [15:0] b_track;
    logic        b_ended;

    logic [7:0]  b;
    logic [7:0]  st;
    logic [31:0] acc;
    logic [31:0] acc_shift;
    logic [31:0] pay_dec;
    logic [3:0]  hi;
    logic        do_step;
    logic        reuse;
    logic [7:0]  s_eff;
    mtep_pkg::mtep_phase_t target;

    assign b = item.data_byte;

    always_comb
    begin
        // Chunk restart clears the parser before the byte is parsed.
        if (item.new_chunk)
        begin
            ph        = mtep_pkg::PH_DELTA;
            b_vlq     = '0;
            b_tick    = '0;
            b_delta   = '0;
            b_payload = '0;
            b_running = '0;
            b_status  = '0;
            b_first   = '0;
            b_meta    = '0;
            b_track   = item.track_index;
            b_ended   = 1'b0;
        end
        else
        begin
            ph        = phase_reg;
            b_vlq     = vlq_reg;
            b_tick    = tick_reg;
            b_delta   = delta_reg;
            b_payload = payload_reg;
            b_running = running_reg;
            b_status  = status_reg;
            b_first   = first_reg;
            b_meta    = meta_reg;
            b_track   = track_reg;
            b_ended   = ended_reg;
        end

        phase_next   = ph;
        vlq_next     = b_vlq;
        tick_next    = b_tick;
        delta_next   = b_delta;
        payload_next = b_payload;
        running_next = b_running;
        status_next  = b_status;
        first_next   = b_first;
        meta_next    = b_meta;
        track_next   = b_track;
        ended_next   = b_ended;

        st      = b_status;
        acc     = b_vlq;
        do_step = !b_ended;

        // Status position: a status byte is stored, a data byte reuses the
        // running status and is then parsed as the following byte.
        reuse = !b[7];
        s_eff = reuse ? b_running : b;
        if (s_eff[7] && (s_eff[7:4] != mtep_pkg::HI_SYSTEM))
        begin
            target = mtep_pkg::PH_DATA1;
        end
        else if ((s_eff == mtep_pkg::STATUS_SYSEX) || (s_eff == mtep_pkg::STATUS_SYSEX_CONT))
        begin
            target = mtep_pkg::PH_SYSLEN;
        end
        else if (s_eff == mtep_pkg::STATUS_META)
        begin
            target = mtep_pkg::PH_METATYPE;
        end
        else
        begin
            target = mtep_pkg::PH_DELTA;
        end

        if (do_step && (ph == mtep_pkg::PH_STATUS))
        begin
            running_next = s_eff;
            status_next  = s_eff;
            st           = s_eff;
            if ((target == mtep_pkg::PH_SYSLEN) || (target == mtep_pkg::PH_DELTA))
            begin
                acc = '0;
            end
            if (reuse)
            begin
                ph = target;
            end
            else
            begin
                phase_next = target;
                vlq_next   = acc;
                do_step    = 1'b0;
            end
        end

        hi        = st[7:4];
        acc_shift = {acc[24:0], b[6:0]};
        pay_dec   = b_payload - 32'd1;

        result               = '0;
        result.delta         = b_delta;
        result.tick          = b_tick;
        result.track         = b_track;
        result.last_in_event = 1'b1;

        if (do_step)
        begin
            phase_next  = ph;
            vlq_next    = acc;
            status_next = st;
            case (ph)
                mtep_pkg::PH_DELTA:
                begin
                    vlq_next = acc_shift;
                    if (!b[7])
                    begin
                        delta_next = acc_shift;
                        tick_next  = b_tick + acc_shift;
                        vlq_next   = '0;
                        phase_next = mtep_pkg::PH_STATUS;
                    end
                end
                mtep_pkg::PH_DATA1:
                begin
                    first_next = b;
                    if ((hi == mtep_pkg::HI_PROGRAM) || (hi == mtep_pkg::HI_CHAN_PRESSURE))
                    begin
                        phase_next     = mtep_pkg::PH_DELTA;
                        vlq_next       = '0;
                        result.valid   = 1'b1;
                        result.kind    = (hi == mtep_pkg::HI_PROGRAM) ?
                                         mtep_pkg::KIND_PROGRAM : mtep_pkg::KIND_CHAN_PRESSURE;
                        result.channel = st[3:0];
                        result.data1   = {6'd0, b};
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2:
                begin
                    phase_next     = mtep_pkg::PH_DELTA;
                    vlq_next       = '0;
                    result.valid   = 1'b1;
                    result.channel = st[3:0];
                    result.data1   = {6'd0, b_first};
                    result.data2   = b;
                    if (hi == mtep_pkg::HI_NOTE_ON)
                    begin
                        result.kind = (b != 8'd0) ? mtep_pkg::KIND_NOTE_ON
                                                  : mtep_pkg::KIND_NOTE_OFF;
                    end
                    else if (hi == mtep_pkg::HI_BEND)
                    begin
                        result.kind  = mtep_pkg::KIND_BEND;
                        result.data1 = {b[6:0], b_first[6:0]};
                        result.data2 = '0;
                    end
                    else if (hi == mtep_pkg::HI_NOTE_OFF)
                    begin
                        result.kind = mtep_pkg::KIND_NOTE_OFF;
                    end
                    else if (hi == mtep_pkg::HI_KEY_PRESSURE)
                    begin
                        result.kind = mtep_pkg::KIND_KEY_PRESSURE;
                    end
                    else
                    begin
                        result.kind = mtep_pkg::KIND_CONTROLLER;
                    end
                end
                mtep_pkg::PH_METATYPE:
                begin
                    meta_next  = b;
                    vlq_next   = '0;
                    phase_next = mtep_pkg::PH_METALEN;
                end
                mtep_pkg::PH_SYSLEN, mtep_pkg::PH_METALEN:
                begin
                    vlq_next = acc_shift;
                    if (!b[7])
                    begin
                        payload_next         = acc_shift;
                        result.valid         = 1'b1;
                        result.length        = acc_shift;
                        result.last_in_event = (acc_shift == 32'd0);
                        if (acc_shift != 32'd0)
                        begin
                            phase_next = mtep_pkg::PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                            vlq_next   = '0;
                            if ((ph == mtep_pkg::PH_METALEN) &&
                                (b_meta == mtep_pkg::META_END_OF_TRACK))
                            begin
                                ended_next = 1'b1;
                            end
                        end
                        if (ph == mtep_pkg::PH_METALEN)
                        begin
                            result.kind         = mtep_pkg::KIND_META;
                            result.data1        = {6'd0, b_meta};
                            result.end_of_track = (b_meta == mtep_pkg::META_END_OF_TRACK);
                        end
                        else
                        begin
                            result.kind  = mtep_pkg::KIND_SYSEX;
                            result.data1 = {6'd0, st};
                        end
                    end
                end
                mtep_pkg::PH_PAYLOAD:
                begin
                    payload_next         = pay_dec;
                    result.valid         = 1'b1;
                    result.kind          = mtep_pkg::KIND_PAYLOAD;
                    result.data1         = {6'd0, b};
                    result.length        = acc;
                    result.last_in_event = (pay_dec == 32'd0);
                    if (pay_dec == 32'd0)
                    begin
                        phase_next = mtep_pkg::PH_DELTA;
                        vlq_next   = '0;
                        if ((st == mtep_pkg::STATUS_META) &&
                            (b_meta == mtep_pkg::META_END_OF_TRACK))
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = mtep_pkg::PH_DELTA;
                    vlq_next   = '0;
                end
            endcase
        end

        result.valid = result.valid && item.valid;
    end

    // Parser state moves only when an item is handed over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mtep_pkg::PH_DELTA;
            vlq_reg     <= '0;
            tick_reg    <= '0;
            delta_reg   <= '0;
            running_reg <= '0;
            status_reg  <= '0;
            first_reg   <= '0;
            meta_reg    <= '0;
            payload_reg <= '0;
            track_reg   <= '0;
            ended_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            vlq_reg     <= vlq_next;
            tick_reg    <= tick_next;
            delta_reg   <= delta_next;
            running_reg <= running_next;
            status_reg  <= status_next;
            first_reg   <= first_next;
            meta_reg    <= meta_next;
            payload_reg <= payload_next;
            track_reg   <= track_next;
            ended_reg   <= ended_next;
        end
    end

endmodule

/* rtl/mtep_out_stage.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result item on the output stream until it is taken.
// ----------------------------------------------------------------------------
module mtep_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  mtep_pkg::mtep_result_t           result,
    output logic                             out_free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // channel[3:0], data1[17:4], data2[25:18], delta[57:26], tick[89:58],
    // length[121:90], track[137:122], zero fill[143:138]
    output logic [mtep_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [mtep_pkg::OUT_USER_W-1:0]  m_tuser,  // kind[3:0], end_of_track[4]
    output logic                             m_tlast   // last_in_event
);

    logic                   valid_reg;
    logic                   valid_next;
    mtep_pkg::mtep_result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = result.valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            res_reg <= result;
        end
    end

    // Pack the result fields, lowest field first.
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.track, res_reg.length, res_reg.tick, res_reg.delta,
                       res_reg.data2, res_reg.data1, res_reg.channel};
    assign m_tuser  = {res_reg.end_of_track, res_reg.kind};
    assign m_tlast  = res_reg.last_in_event;

endmodule

/* rtl/midi_track_event_parser_top.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser, top level
// Decodes the body bytes of a standard MIDI file track chunk into event items.
// ----------------------------------------------------------------------------
// Feed the track chunk body one byte per item, with tuser (new_chunk) high on
// the first byte of each track. Each byte is held in an input register,
// decoded by the parser step in a single pass and, when it completes an
// event or carries a sysex or meta payload byte, lands in the result
// register. A new byte is taken every cycle as long as the result register
// is empty or is being read, so throughput is one byte per cycle. Channel
// messages give one item; sysex and meta give a header item and then one
// item per payload byte, with tlast on the final item of each event. After
// an end-of-track meta event all bytes are dropped until the next new_chunk.
module midi_track_event_parser_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mtep_pkg::IN_DATA_W-1:0]   s_tdata,   // data_byte[7:0], track_index[23:8]
    input  logic                             s_tuser,   // new_chunk
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // channel[3:0], data1[17:4], data2[25:18], delta[57:26], tick[89:58],
    // length[121:90], track[137:122], zero fill[143:138]
    output logic [mtep_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [mtep_pkg::OUT_USER_W-1:0]  m_tuser,   // kind[3:0], end_of_track[4]
    output logic                             m_tlast    // last_in_event
);

    mtep_pkg::mtep_item_t   item;
    mtep_pkg::mtep_result_t result;
    logic                   advance;
    logic                   out_free;

    // Input register.
    mtep_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    // Parser state and single-pass decode.
    mtep_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    // Result register.
    mtep_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // An empty input register always takes a byte.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item.valid |-> s_tready)
        else $error("input side stalled with an empty input register");

    // End of track is flagged only on meta headers.
    a_eot_meta_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> (m_tuser[3:0] == mtep_pkg::KIND_META))
        else $error("end_of_track on a non-meta item");

    // A zero-length sysex or meta header closes its event.
    a_empty_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser[3:0] == mtep_pkg::KIND_SYSEX) ||
                      (m_tuser[3:0] == mtep_pkg::KIND_META)) &&
         (m_tdata[121:90] == 32'd0)) |-> m_tlast)
        else $error("zero-length header without last_in_event");

    // A handed-over item with a result fills the result register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.valid) |=> m_tvalid)
        else $error("result lost between parser and result register");

endmodule
